/* design/gpio_prb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port register block package
// Word offsets, pin codes and the request and result types that the core
// and the top level share.
// ----------------------------------------------------------------------------
package gpio_prb_pkg;

  localparam int MAX_PINS = 64;
  localparam int FSEL_WORDS = 6;
  localparam int PINS_PER_FSEL = 10;

  localparam logic [5:0] FSEL_LAST_WORD = 6'd5;
  localparam logic [5:0] SET0_WORD = 6'd7;
  localparam logic [5:0] SET1_WORD = 6'd8;
  localparam logic [5:0] CLR0_WORD = 6'd10;
  localparam logic [5:0] CLR1_WORD = 6'd11;
  localparam logic [5:0] LEV0_WORD = 6'd13;
  localparam logic [5:0] LEV1_WORD = 6'd14;
  localparam logic [5:0] PUD_WORD = 6'd37;
  localparam logic [5:0] PUDCLK0_WORD = 6'd38;
  localparam logic [5:0] PUDCLK1_WORD = 6'd39;

  localparam logic [2:0] FSEL_OUTPUT = 3'd1;
  localparam logic [1:0] PULL_DOWN = 2'd1;
  localparam logic [1:0] PULL_UP = 2'd2;

  typedef struct packed {
    logic        wr;
    logic [5:0]  offset;
    logic [31:0] wdata;
    logic [63:0] pads;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [63:0] drive;
    logic [63:0] enable;
    logic [63:0] pull_up;
    logic [63:0] pull_down;
  } res_t;

endpackage
`default_nettype wire

/* design/gpio_prb_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port register core
// Holds the per-pin state, decodes one access, and forms the read word and
// the pin masks that follow from the state after the access.
// ----------------------------------------------------------------------------
module gpio_prb_core #(
  parameter int NUM_PINS = 54
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      accept_i,
  input  wire gpio_prb_pkg::req_t  req_i,
  output gpio_prb_pkg::res_t       res_o
);

  logic [2:0] fsel_q [NUM_PINS];
  logic [2:0] fsel_d [NUM_PINS];
  logic       latch_q [NUM_PINS];
  logic       latch_d [NUM_PINS];
  logic [1:0] pull_q [NUM_PINS];
  logic [1:0] pull_d [NUM_PINS];
  logic [1:0] pull_code_q;
  logic [1:0] pull_code_d;

  logic [31:0] fsel_word [gpio_prb_pkg::FSEL_WORDS];
  logic [63:0] pads_masked;
  logic [63:0] pin_mask;
  logic [31:0] rdata;
  logic        do_wr;

  assign do_wr = accept_i && req_i.wr;

  for (genvar w = 0; w < gpio_prb_pkg::FSEL_WORDS; w++) begin : g_fword
    for (genvar s = 0; s < gpio_prb_pkg::PINS_PER_FSEL; s++) begin : g_slot
      localparam int Pin = w * gpio_prb_pkg::PINS_PER_FSEL + s;
      if (Pin < NUM_PINS) begin : g_pin
        assign fsel_word[w][3*s +: 3] = fsel_q[Pin];
      end else begin : g_none
        assign fsel_word[w][3*s +: 3] = 3'd0;
      end
    end
    assign fsel_word[w][31:30] = 2'd0;
  end

  for (genvar b = 0; b < gpio_prb_pkg::MAX_PINS; b++) begin : g_mask
    assign pin_mask[b] = (b < NUM_PINS);
  end

  assign pads_masked = req_i.pads & pin_mask;

  for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
    localparam int Word = p / gpio_prb_pkg::PINS_PER_FSEL;
    localparam int Slot = p % gpio_prb_pkg::PINS_PER_FSEL;
    localparam int Bit = p % 32;
    localparam logic Hi = (p >= 32);

    always_comb begin
      fsel_d[p] = fsel_q[p];
      latch_d[p] = latch_q[p];
      pull_d[p] = pull_q[p];
      if (do_wr) begin
        if ((Word < gpio_prb_pkg::FSEL_WORDS) && (req_i.offset == 6'(Word))) begin
          fsel_d[p] = req_i.wdata[3*Slot +: 3];
        end
        if (req_i.wdata[Bit]) begin
          if (req_i.offset == (Hi ? gpio_prb_pkg::SET1_WORD : gpio_prb_pkg::SET0_WORD)) begin
            latch_d[p] = 1'b1;
          end
          if (req_i.offset == (Hi ? gpio_prb_pkg::CLR1_WORD : gpio_prb_pkg::CLR0_WORD)) begin
            latch_d[p] = 1'b0;
          end
          if (req_i.offset ==
              (Hi ? gpio_prb_pkg::PUDCLK1_WORD : gpio_prb_pkg::PUDCLK0_WORD)) begin
            pull_d[p] = pull_code_q;
          end
        end
      end
    end

    assign res_o.drive[p] = latch_d[p];
    assign res_o.enable[p] = (fsel_d[p] == gpio_prb_pkg::FSEL_OUTPUT);
    assign res_o.pull_up[p] = (pull_d[p] == gpio_prb_pkg::PULL_UP);
    assign res_o.pull_down[p] = (pull_d[p] == gpio_prb_pkg::PULL_DOWN);
  end

  for (genvar p = NUM_PINS; p < gpio_prb_pkg::MAX_PINS; p++) begin : g_absent
    assign res_o.drive[p] = 1'b0;
    assign res_o.enable[p] = 1'b0;
    assign res_o.pull_up[p] = 1'b0;
    assign res_o.pull_down[p] = 1'b0;
  end

  always_comb begin
    pull_code_d = pull_code_q;
    if (do_wr && (req_i.offset == gpio_prb_pkg::PUD_WORD)) begin
      pull_code_d = req_i.wdata[1:0];
    end
  end

  always_comb begin
    rdata = 32'd0;
    if (!req_i.wr) begin
      if (req_i.offset <= gpio_prb_pkg::FSEL_LAST_WORD) begin
        rdata = fsel_word[req_i.offset[2:0]];
      end else if (req_i.offset == gpio_prb_pkg::LEV0_WORD) begin
        rdata = pads_masked[31:0];
      end else if (req_i.offset == gpio_prb_pkg::LEV1_WORD) begin
        rdata = pads_masked[63:32];
      end else if (req_i.offset == gpio_prb_pkg::PUD_WORD) begin
        rdata = {30'd0, pull_code_q};
      end
    end
  end

  assign res_o.rdata = rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q <= '{default: '0};
      latch_q <= '{default: '0};
      pull_q <= '{default: '0};
      pull_code_q <= 2'd0;
    end else if (accept_i) begin
      fsel_q <= fsel_d;
      latch_q <= latch_d;
      pull_q <= pull_d;
      pull_code_q <= pull_code_d;
    end
  end

endmodule
`default_nettype wire

/* design/gpio_port_register_block.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port register block
// One bus access per item; each item yields one result with the read word
// and the output, enable and pull masks of all pins.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while not stalled and shows its result
// in the next cycle from a single result register; the decode and the state
// update sit between the input ports and that register. While the result
// register holds an item that the far side stalls, the input stalls too.
// Function-select words 0 to 5, set words 7 and 8, clear words 10 and 11,
// level words 13 and 14, pull control word 37 and pull-clock words 38 and 39
// are mapped; everything else reads as zero and ignores writes.
module gpio_port_register_block #(
  parameter int NUM_PINS = 54
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         req_type_i,
  input  wire  [5:0]  word_offset_i,
  input  wire  [31:0] write_data_i,
  input  wire  [31:0] pads_in_low_i,
  input  wire  [21:0] pads_in_high_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] read_data_o,
  output logic [31:0] drive_low_o,
  output logic [21:0] drive_high_o,
  output logic [31:0] enable_low_o,
  output logic [21:0] enable_high_o,
  output logic [31:0] pull_up_low_o,
  output logic [21:0] pull_up_high_o,
  output logic [31:0] pull_down_low_o,
  output logic [21:0] pull_down_high_o
);

  gpio_prb_pkg::req_t req;
  gpio_prb_pkg::res_t res;
  gpio_prb_pkg::res_t res_q;
  logic               valid_q;
  logic               in_accept;

  assign in_stall_o = valid_q && out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;

  assign req.wr = req_type_i;
  assign req.offset = word_offset_i;
  assign req.wdata = write_data_i;
  assign req.pads = {10'd0, pads_in_high_i, pads_in_low_i};

  gpio_prb_core #(
    .NUM_PINS (NUM_PINS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .req_i    (req),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_accept) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o = valid_q;
  assign read_data_o = res_q.rdata;
  assign drive_low_o = res_q.drive[31:0];
  assign drive_high_o = res_q.drive[53:32];
  assign enable_low_o = res_q.enable[31:0];
  assign enable_high_o = res_q.enable[53:32];
  assign pull_up_low_o = res_q.pull_up[31:0];
  assign pull_up_high_o = res_q.pull_up[53:32];
  assign pull_down_low_o = res_q.pull_down[31:0];
  assign pull_down_high_o = res_q.pull_down[53:32];

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && req_type_i) |=> (read_data_o == 32'd0))
    else $error("write item returned nonzero read data");

  a_pull_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pull_up_low_o & pull_down_low_o) == 32'd0))
    else $error("pin shows pull-up and pull-down at once");

endmodule
`default_nettype wire
